// ===== hw/rtl/gpw_pkg.sv =====
// gpw_pkg: sizes, codes, fixed-point constants and shared types of the
// Gaussian pair weight evaluator. No dependencies.
package gpw_pkg;

	localparam int unsigned MAX_ATOMS      = 64;
	localparam int unsigned TERMS_PER_ATOM = 2;
	localparam int unsigned N_TERMS        = MAX_ATOMS * TERMS_PER_ATOM;

	localparam int unsigned ATOM_W = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
	localparam int unsigned TERM_W = (TERMS_PER_ATOM > 1) ? $clog2(TERMS_PER_ATOM) : 1;
	localparam int unsigned TIDX_W = (N_TERMS > 1) ? $clog2(N_TERMS) : 1;
	localparam int unsigned CNT_W  = $clog2(MAX_ATOMS + 1);
	localparam int unsigned INFL_W = 7;

	// operation codes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	// status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_OVF  = 2'd2;

	localparam logic [63:0] SAT_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [21:0] ARG_CAP   = 22'h20_0000;   // 32.0 in Q16.16
	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
	localparam logic [31:0] LN2_Q32   = 32'd2977044472;
	localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;

	// Horner series cells, divisor of cell i is N_CELLS - i
	localparam int unsigned N_CELLS = 12;
	localparam logic [34:0] RECIP [N_CELLS] = '{
		35'((64'd1 << 34) / 64'd12), 35'((64'd1 << 34) / 64'd11),
		35'((64'd1 << 34) / 64'd10), 35'((64'd1 << 34) / 64'd9),
		35'((64'd1 << 34) / 64'd8),  35'((64'd1 << 34) / 64'd7),
		35'((64'd1 << 34) / 64'd6),  35'((64'd1 << 34) / 64'd5),
		35'((64'd1 << 34) / 64'd4),  35'((64'd1 << 34) / 64'd3),
		35'((64'd1 << 34) / 64'd2),  35'((64'd1 << 34) / 64'd1)
	};

	typedef struct packed {
		logic        pt;      // 0: first point, 1: second point
		logic        zero;    // argument saturated, term contributes nothing
		logic [5:0]  k;       // integer part of the base-2 exponent
		logic [31:0] weight;
	} side_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] x;
		logic [32:0] e;
		side_t       side;
	} chain_t;

endpackage

// ===== hw/rtl/gpw_req_if.sv =====
// gpw_req_if: input channel of the evaluator, valid/ready plus item fields.
// No dependencies.
interface gpw_req_if;
	logic               valid;
	logic               ready;
	logic               operation;
	logic [5:0]         slot;
	logic               term;
	logic signed [31:0] px;
	logic signed [31:0] py;
	logic signed [31:0] pz;
	logic signed [31:0] qx;
	logic signed [31:0] qy;
	logic signed [31:0] qz;
	logic [31:0]        exponent;
	logic [31:0]        weight;
	logic [31:0]        distance;

	modport source (output valid, operation, slot, term, px, py, pz, qx, qy, qz,
		exponent, weight, distance, input ready);
	modport sink (input valid, operation, slot, term, px, py, pz, qx, qy, qz,
		exponent, weight, distance, output ready);
endinterface

// ===== hw/rtl/gpw_rsp_if.sv =====
// gpw_rsp_if: result channel of the evaluator, valid/ready plus value and status.
// No dependencies.
interface gpw_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] value;
	logic [1:0]         status;

	modport source (output valid, value, status, input ready);
	modport sink (input valid, value, status, output ready);
endinterface

// ===== hw/rtl/gpw_ram.sv =====
// gpw_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module gpw_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/gpw_arg.sv =====
// gpw_arg: squared distance, scaled argument and range reduction of one term.
// Seven stages; depends on gpw_pkg.
module gpw_arg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid,
	input  logic                 pt,
	input  logic [31:0]          pnt_x,
	input  logic [31:0]          pnt_y,
	input  logic [31:0]          pnt_z,
	input  logic [31:0]          ctr_x,
	input  logic [31:0]          ctr_y,
	input  logic [31:0]          ctr_z,
	input  logic [31:0]          exponent,
	input  logic [31:0]          weight,
	output gpw_pkg::chain_t      c_out
);
	localparam logic [30:0] LOG2E_Q30_l = gpw_pkg::LOG2E_Q30;

	logic [6:0]  v_q;
	logic [6:0]  pt_q;
	logic [31:0] ex_q [6];
	logic [31:0] w_q  [6];

	logic [31:0] mag_s1 [3];
	logic [47:0] sq_s2  [3];
	logic [49:0] d2_s3;
	logic [49:0] hi_s4;
	logic [47:0] lo_s4;
	logic [21:0] t_s5;
	logic        zero_s5, zero_s6;
	logic [5:0]  k_s6;
	logic [31:0] g_s6;
	logic [31:0] x_s7;
	gpw_pkg::side_t side_s7;

	logic [32:0] diff [3];
	logic [63:0] lo_full;
	logic [48:0] t_full;
	logic [52:0] u_full;
	logic [63:0] x_full;

	always_comb begin
		diff[0] = {pnt_x[31], pnt_x} - {ctr_x[31], ctr_x};
		diff[1] = {pnt_y[31], pnt_y} - {ctr_y[31], ctr_y};
		diff[2] = {pnt_z[31], pnt_z} - {ctr_z[31], ctr_z};
		lo_full = ex_q[2] * d2_s3[31:0];
		t_full  = {28'd0, hi_s4[4:0], 16'd0} + {1'b0, lo_s4};
		u_full  = t_s5 * LOG2E_Q30_l;
		x_full  = g_s6 * gpw_pkg::LN2_Q32;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[5:0], valid};
		end
	end

	always_ff @(posedge clk) begin
		pt_q    <= {pt_q[5:0], pt};
		ex_q[0] <= exponent;
		w_q[0]  <= weight;
		for (int i = 1; i < 6; i++) begin
			ex_q[i] <= ex_q[i-1];
			w_q[i]  <= w_q[i-1];
		end
		// s1: coordinate difference magnitudes
		for (int i = 0; i < 3; i++) begin
			mag_s1[i] <= diff[i][32] ? 32'(-diff[i]) : diff[i][31:0];
		end
		// s2: squares to Q16.16
		for (int i = 0; i < 3; i++) begin
			sq_s2[i] <= 48'((64'(mag_s1[i]) * 64'(mag_s1[i])) >> 16);
		end
		// s3: squared distance
		d2_s3 <= {2'b0, sq_s2[0]} + {2'b0, sq_s2[1]} + {2'b0, sq_s2[2]};
		// s4: exponent times squared distance, high and low halves
		hi_s4 <= ex_q[2] * d2_s3[49:32];
		lo_s4 <= lo_full[63:16];
		// s5: argument, capped at 32.0
		if (hi_s4 >= 50'd32 || t_full > 49'(gpw_pkg::ARG_CAP)) begin
			t_s5    <= gpw_pkg::ARG_CAP;
			zero_s5 <= 1'b1;
		end else begin
			t_s5    <= t_full[21:0];
			zero_s5 <= (t_full[21:0] == gpw_pkg::ARG_CAP);
		end
		// s6: base-2 exponent, split into integer and fraction
		k_s6    <= u_full[51:46];
		g_s6    <= u_full[45:14];
		zero_s6 <= zero_s5;
		// s7: fraction times ln 2
		x_s7           <= x_full[63:32];
		side_s7.pt     <= pt_q[5];
		side_s7.zero   <= zero_s6;
		side_s7.k      <= k_s6;
		side_s7.weight <= w_q[5];
	end

	assign c_out = {v_q[6], x_s7, gpw_pkg::ONE_Q32, side_s7};
endmodule

// ===== hw/rtl/gpw_cell.sv =====
// gpw_cell: one Horner step of the exp series, e' = 1 - (x*e)/m, in three
// stages with exact division by the constant m. Depends on gpw_pkg.
module gpw_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  gpw_pkg::chain_t c_in,
	input  logic [3:0]      m,
	input  logic [34:0]     recip,
	output gpw_pkg::chain_t c_out
);
	logic            v_s1, v_s2, v_s3;
	logic [31:0]     p_s1, p_s2, q0_s2;
	logic [31:0]     x_s1, x_s2, x_s3;
	logic [32:0]     e_s3;
	gpw_pkg::side_t  side_s1, side_s2, side_s3;

	logic [64:0] xe;
	logic [66:0] pr;
	logic [35:0] qm, r;
	logic [31:0] q;

	always_comb begin
		xe = c_in.x * c_in.e;
		pr = p_s1 * recip;
		qm = q0_s2 * m;
		r  = {4'd0, p_s2} - qm;
		// estimate is low by at most one
		q  = (r >= 36'(m)) ? q0_s2 + 32'd1 : q0_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= c_in.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		p_s1    <= xe[63:32];
		x_s1    <= c_in.x;
		side_s1 <= c_in.side;
		p_s2    <= p_s1;
		q0_s2   <= pr[65:34];
		x_s2    <= x_s1;
		side_s2 <= side_s1;
		x_s3    <= x_s2;
		e_s3    <= gpw_pkg::ONE_Q32 - {1'b0, q};
		side_s3 <= side_s2;
	end

	assign c_out = {v_s3, x_s3, e_s3, side_s3};
endmodule

// ===== hw/rtl/gaussian_pair_weight_eval.sv =====
// gaussian_pair_weight_eval: top level, sequencer, tables, exp cell chain,
// sums, product and quotient. Depends on gpw_pkg, gpw_req_if, gpw_rsp_if,
// gpw_ram, gpw_arg and gpw_cell.
//
// A load transfer returns value 0, status ok. An evaluate transfer with zero
// distance returns the saturated value with status 1. Any other evaluate walks
// every term of every atom in use, first for P then for Q, one term per cycle
// into a pipeline: table read, seven stages of squared distance and argument
// reduction, a chain of twelve Horner cells (three stages each) that form
// exp(-t), and two tail stages that weight and accumulate the term. After the
// pipeline drains, the two 64-bit sums are multiplied in four 32x32 partial
// products and divided one quotient bit per cycle. The sequence is table read,
// pipeline and drain check, 4 multiply steps, 128 divide steps and the load of
// the output register. With atoms_in_use capped at MAX_ATOMS equal to 0, the
// issue loop and drain are skipped.
// The next transfer is taken once the result has been loaded into the output
// register and that register is free or being drained. Tables are not cleared
// at reset; evaluating with unwritten slots in use gives undefined values.
module gaussian_pair_weight_eval (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [6:0]        cfg_wr_data,
	gpw_req_if.sink           req,
	gpw_rsp_if.source         rsp
);
	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_ISSUE = 6'b000010,
		S_DRAIN = 6'b000100,
		S_MUL   = 6'b001000,
		S_DIV   = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t state_q;

	logic [6:0]                  atoms_q;
	logic [gpw_pkg::CNT_W-1:0]   n_q, n_cap;
	logic [gpw_pkg::ATOM_W-1:0]  a_q;
	logic [gpw_pkg::TERM_W-1:0]  t_q;
	logic                        pt_q;
	logic [31:0]                 px_q, py_q, pz_q, qx_q, qy_q, qz_q;
	logic [47:0]                 den_q;
	logic                        issue_v_s1, issue_pt_s1;
	logic [gpw_pkg::INFL_W-1:0]  infl_q;
	logic [63:0]                 sum_q [2];
	logic [127:0]                prod_q;
	logic [1:0]                  mstep_q;
	logic [6:0]                  div_cnt_q;
	logic [47:0]                 rem_q;
	logic [63:0]                 quo_q;
	logic                        ovf_q;
	logic                        out_v_q;
	logic [63:0]                 out_value_q;
	logic [1:0]                  out_status_q;

	// handshake and decode
	logic accept, is_load, is_eval, load_ok, out_free, done_fire;
	logic term_last, atom_last, issue_last, issue;

	assign out_free  = !out_v_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	assign accept    = req.valid && req.ready;
	assign is_load   = accept && (req.operation == gpw_pkg::OP_LOAD);
	assign is_eval   = accept && (req.operation == gpw_pkg::OP_EVAL);
	assign load_ok   = (32'(req.slot) < gpw_pkg::MAX_ATOMS) &&
		(32'(req.term) < gpw_pkg::TERMS_PER_ATOM);
	assign done_fire = (state_q == S_DONE) && out_free;

	assign n_cap = (32'(atoms_q) > gpw_pkg::MAX_ATOMS) ?
		gpw_pkg::CNT_W'(gpw_pkg::MAX_ATOMS) : gpw_pkg::CNT_W'(atoms_q);

	assign issue      = (state_q == S_ISSUE);
	assign term_last  = (t_q == gpw_pkg::TERM_W'(gpw_pkg::TERMS_PER_ATOM - 1));
	assign atom_last  = ((gpw_pkg::CNT_W'(a_q) + gpw_pkg::CNT_W'(1)) == n_q);
	assign issue_last = issue && term_last && atom_last;

	// tables: center per atom, exponent and weight per term
	logic [gpw_pkg::ATOM_W-1:0] ctr_waddr;
	logic [gpw_pkg::TIDX_W-1:0] trm_waddr, trm_raddr;
	logic [95:0]                ctr_rdata;
	logic [63:0]                trm_rdata;

	assign ctr_waddr = gpw_pkg::ATOM_W'(req.slot);
	assign trm_waddr = gpw_pkg::TIDX_W'(32'(req.slot) * gpw_pkg::TERMS_PER_ATOM + 32'(req.term));
	assign trm_raddr = gpw_pkg::TIDX_W'(32'(a_q) * gpw_pkg::TERMS_PER_ATOM + 32'(t_q));

	gpw_ram #(.WIDTH(96), .DEPTH(gpw_pkg::MAX_ATOMS)) u_ctr_ram (
		.clk   (clk),
		.we    (is_load && load_ok),
		.waddr (ctr_waddr),
		.wdata ({req.pz, req.py, req.px}),
		.raddr (a_q),
		.rdata (ctr_rdata)
	);

	gpw_ram #(.WIDTH(64), .DEPTH(gpw_pkg::N_TERMS)) u_trm_ram (
		.clk   (clk),
		.we    (is_load && load_ok),
		.waddr (trm_waddr),
		.wdata ({req.weight, req.exponent}),
		.raddr (trm_raddr),
		.rdata (trm_rdata)
	);

	// argument front end and exp cell chain
	gpw_pkg::chain_t chain [gpw_pkg::N_CELLS+1];

	gpw_arg u_arg (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (issue_v_s1),
		.pt       (issue_pt_s1),
		.pnt_x    (issue_pt_s1 ? qx_q : px_q),
		.pnt_y    (issue_pt_s1 ? qy_q : py_q),
		.pnt_z    (issue_pt_s1 ? qz_q : pz_q),
		.ctr_x    (ctr_rdata[31:0]),
		.ctr_y    (ctr_rdata[63:32]),
		.ctr_z    (ctr_rdata[95:64]),
		.exponent (trm_rdata[31:0]),
		.weight   (trm_rdata[63:32]),
		.c_out    (chain[0])
	);

	for (genvar i = 0; i < gpw_pkg::N_CELLS; i++) begin : g_cell
		gpw_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.c_in   (chain[i]),
			.m      (4'(gpw_pkg::N_CELLS - i)),
			.recip  (gpw_pkg::RECIP[i]),
			.c_out  (chain[i+1])
		);
	end

	// tail: 2^-k scaling, weighting, accumulation
	logic        tail_v_s1, tail_v_s2, tail_pt_s1, tail_pt_s2;
	logic [32:0] es_s1;
	logic [31:0] w_s1;
	logic [48:0] contrib_s2;
	logic [64:0] wes;

	assign wes = w_s1 * es_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_v_s1 <= 1'b0;
			tail_v_s2 <= 1'b0;
		end else begin
			tail_v_s1 <= chain[gpw_pkg::N_CELLS].valid;
			tail_v_s2 <= tail_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		es_s1      <= chain[gpw_pkg::N_CELLS].side.zero ? 33'd0 :
			(chain[gpw_pkg::N_CELLS].e >> chain[gpw_pkg::N_CELLS].side.k);
		w_s1       <= chain[gpw_pkg::N_CELLS].side.weight;
		tail_pt_s1 <= chain[gpw_pkg::N_CELLS].side.pt;
		contrib_s2 <= wes[64:16];
		tail_pt_s2 <= tail_pt_s1;
	end

	// product partial terms and divider step
	logic [31:0]  mul_a, mul_b;
	logic [63:0]  pp;
	logic [1:0]   pp_sh;
	logic [48:0]  rem2;
	logic         rem_ge;

	assign mul_a  = mstep_q[1] ? sum_q[0][63:32] : sum_q[0][31:0];
	assign mul_b  = mstep_q[0] ? sum_q[1][63:32] : sum_q[1][31:0];
	assign pp     = mul_a * mul_b;
	assign pp_sh  = {1'b0, mstep_q[1]} + {1'b0, mstep_q[0]};
	assign rem2   = {rem_q, prod_q[127]};
	assign rem_ge = (rem2 >= {1'b0, den_q});

	// sequencer and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			atoms_q     <= '0;
			issue_v_s1  <= 1'b0;
			infl_q      <= '0;
			out_v_q     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				atoms_q <= cfg_wr_data;
			end
			issue_v_s1 <= issue;
			infl_q     <= infl_q + gpw_pkg::INFL_W'(issue) - gpw_pkg::INFL_W'(tail_v_s2);

			if (is_load || (is_eval && req.distance == 32'd0) || done_fire) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (is_eval && req.distance != 32'd0) begin
						state_q <= (n_cap == '0) ? S_MUL : S_ISSUE;
					end
				end
				S_ISSUE: begin
					if (issue_last && pt_q) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (infl_q == '0) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (mstep_q == 2'd3) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_cnt_q == 7'd0) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (done_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		issue_pt_s1 <= pt_q;

		if (is_eval) begin
			n_q     <= n_cap;
			a_q     <= '0;
			t_q     <= '0;
			pt_q    <= 1'b0;
			px_q    <= req.px;
			py_q    <= req.py;
			pz_q    <= req.pz;
			qx_q    <= req.qx;
			qy_q    <= req.qy;
			qz_q    <= req.qz;
			den_q   <= {req.distance, 16'd0};
			sum_q[0] <= '0;
			sum_q[1] <= '0;
			prod_q  <= '0;
			mstep_q <= '0;
		end

		if (issue) begin
			if (term_last) begin
				t_q <= '0;
				if (atom_last) begin
					a_q  <= '0;
					pt_q <= 1'b1;
				end else begin
					a_q <= a_q + gpw_pkg::ATOM_W'(1);
				end
			end else begin
				t_q <= t_q + gpw_pkg::TERM_W'(1);
			end
		end

		if (tail_v_s2) begin
			sum_q[tail_pt_s2] <= sum_q[tail_pt_s2] + 64'(contrib_s2);
		end

		if (state_q == S_MUL) begin
			prod_q  <= prod_q + (128'(pp) << {pp_sh, 5'd0});
			mstep_q <= mstep_q + 2'd1;
			if (mstep_q == 2'd3) begin
				div_cnt_q <= 7'd127;
				rem_q     <= '0;
				quo_q     <= '0;
				ovf_q     <= 1'b0;
			end
		end

		if (state_q == S_DIV) begin
			// restoring division, one quotient bit per cycle
			prod_q    <= {prod_q[126:0], 1'b0};
			rem_q     <= rem_ge ? 48'(rem2 - {1'b0, den_q}) : rem2[47:0];
			quo_q     <= {quo_q[62:0], rem_ge};
			div_cnt_q <= div_cnt_q - 7'd1;
			if (rem_ge && div_cnt_q >= 7'd63) begin
				ovf_q <= 1'b1;
			end
		end

		// result payload
		if (is_load) begin
			out_value_q  <= '0;
			out_status_q <= gpw_pkg::ST_OK;
		end else if (is_eval && req.distance == 32'd0) begin
			out_value_q  <= gpw_pkg::SAT_MAX;
			out_status_q <= gpw_pkg::ST_ZERO;
		end else if (done_fire) begin
			out_value_q  <= ovf_q ? gpw_pkg::SAT_MAX : quo_q;
			out_status_q <= ovf_q ? gpw_pkg::ST_OVF : gpw_pkg::ST_OK;
		end
	end

	assign rsp.valid  = out_v_q;
	assign rsp.value  = out_value_q;
	assign rsp.status = out_status_q;
endmodule

// ===== hw/rtl/gpw_chk.sv =====
// gpw_chk: port-level assertions for the evaluator and the bind that attaches
// them to the top level. Depends on gpw_pkg and gaussian_pair_weight_eval.
module gpw_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [63:0] rsp_value,
	input logic [1:0]  rsp_status
);
	// a pending result is held until transferred
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_status <= gpw_pkg::ST_OVF)
		else $error("undefined status code");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != gpw_pkg::ST_OK |-> rsp_value == gpw_pkg::SAT_MAX)
		else $error("flagged result not saturated");

	a_ok_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == gpw_pkg::ST_OK |-> !rsp_value[63])
		else $error("unflagged quotient out of range");
endmodule

bind gaussian_pair_weight_eval gpw_chk u_gpw_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_value  (rsp.value),
	.rsp_status (rsp.status)
);

// ===== test/gpw_weight_checker.sv =====
// gpw_weight_checker: watches the request, result and register ports of the
// Gaussian pair weight evaluator, predicts every result and compares it.
// Depends on gpw_pkg, gpw_req_if and gpw_rsp_if.
module gpw_weight_checker
	import gpw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [6:0] cfg_wr_data,
	gpw_req_if         req,
	gpw_rsp_if         rsp,
	output int         errors,
	output int         outstanding
);

	typedef struct {
		logic [63:0] value;
		logic [1:0]  status;
	} weight_result_t;

	weight_result_t expected_weights[$];

	logic [31:0] atom_x [MAX_ATOMS];
	logic [31:0] atom_y [MAX_ATOMS];
	logic [31:0] atom_z [MAX_ATOMS];
	logic [31:0] term_expo [N_TERMS];
	logic [31:0] term_wt [N_TERMS];
	logic [6:0]  atoms_used;

	// squared coordinate difference, Q16.16
	function automatic logic [63:0] axis_sq(logic [31:0] a, logic [31:0] c);
		logic signed [33:0] d;
		logic [33:0]        mag;
		logic [63:0]        m;
		d   = $signed({{2{a[31]}}, a}) - $signed({{2{c[31]}}, c});
		mag = d[33] ? -d : d;
		m   = 64'(mag);
		return (m * m) >> 16;
	endfunction

	// exponent times squared distance, capped at 32.0
	function automatic logic [63:0] gauss_arg(logic [31:0] a, logic [63:0] d2);
		logic [63:0] hi;
		logic [63:0] t;
		hi = 64'(a) * (d2 >> 32);
		if (hi >= 64'd32)
			return 64'(ARG_CAP);
		t = (hi << 16) + ((64'(a) * (d2 & 64'hFFFF_FFFF)) >> 16);
		return (t > 64'(ARG_CAP)) ? 64'(ARG_CAP) : t;
	endfunction

	// exp(-t) in Q0.32: power of two split plus 12-step Horner series
	function automatic logic [63:0] exp_decay(logic [63:0] t);
		logic [63:0] u;
		logic [63:0] k;
		logic [63:0] x;
		logic [63:0] e;
		if (t >= 64'(ARG_CAP))
			return 64'd0;
		u = (t * 64'(LOG2E_Q30)) >> 14;
		k = u >> 32;
		x = ((u & 64'hFFFF_FFFF) * 64'(LN2_Q32)) >> 32;
		e = 64'(ONE_Q32);
		for (int m = N_CELLS; m >= 1; m--)
			e = 64'(ONE_Q32) - (((x * e) >> 32) / 64'(m));
		return e >> k;
	endfunction

	function automatic logic [63:0] density_sum(logic [31:0] x, logic [31:0] y,
			logic [31:0] z, int n);
		logic [63:0] s;
		logic [63:0] d2;
		int          idx;
		s = 0;
		for (int i = 0; i < n; i++) begin
			d2 = axis_sq(x, atom_x[i]) + axis_sq(y, atom_y[i]) + axis_sq(z, atom_z[i]);
			for (int j = 0; j < TERMS_PER_ATOM; j++) begin
				idx = i * TERMS_PER_ATOM + j;
				s += (64'(term_wt[idx]) * exp_decay(gauss_arg(term_expo[idx], d2))) >> 16;
			end
		end
		return s;
	endfunction

	function automatic weight_result_t pair_weight();
		weight_result_t r;
		logic [63:0]    s1;
		logic [63:0]    s2;
		logic [127:0]   prod;
		logic [127:0]   quo;
		int             n;
		n = (atoms_used > MAX_ATOMS) ? MAX_ATOMS : int'(atoms_used);
		r.value  = 0;
		r.status = ST_OK;
		if (req.distance == 0) begin
			r.value  = SAT_MAX;
			r.status = ST_ZERO;
			return r;
		end
		s1   = density_sum(req.px, req.py, req.pz, n);
		s2   = density_sum(req.qx, req.qy, req.qz, n);
		prod = 128'(s1) * 128'(s2);
		quo  = prod / (128'(req.distance) << 16);
		if (quo >= (128'd1 << 63)) begin
			r.value  = SAT_MAX;
			r.status = ST_OVF;
		end else begin
			r.value = quo[63:0];
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		weight_result_t got;
		weight_result_t want;
		if (!arst_n) begin
			expected_weights.delete();
			atoms_used  = 0;
			errors      = 0;
			outstanding = 0;
			for (int i = 0; i < MAX_ATOMS; i++) begin
				atom_x[i] = 0;
				atom_y[i] = 0;
				atom_z[i] = 0;
			end
			for (int i = 0; i < N_TERMS; i++) begin
				term_expo[i] = 0;
				term_wt[i]   = 0;
			end
		end else begin
			// result side first: a result can never belong to a same-edge request
			if (rsp.valid && rsp.ready) begin
				got.value  = rsp.value;
				got.status = rsp.status;
				if (expected_weights.size() == 0) begin
					$display("%0t: unexpected result value %h status %0d", $time,
						got.value, got.status);
					errors++;
				end else begin
					want = expected_weights.pop_front();
					if (got.value !== want.value) begin
						$display("%0t: value mismatch expected %h actual %h", $time,
							want.value, got.value);
						errors++;
					end
					if (got.status !== want.status) begin
						$display("%0t: status mismatch expected %0d actual %0d", $time,
							want.status, got.status);
						errors++;
					end
				end
			end
			if (req.valid && req.ready) begin
				if (req.operation == OP_LOAD) begin
					atom_x[req.slot] = req.px;
					atom_y[req.slot] = req.py;
					atom_z[req.slot] = req.pz;
					term_expo[req.slot * TERMS_PER_ATOM + req.term] = req.exponent;
					term_wt[req.slot * TERMS_PER_ATOM + req.term]   = req.weight;
					want.value  = 0;
					want.status = ST_OK;
				end else begin
					want = pair_weight();
				end
				expected_weights.push_back(want);
			end
			if (cfg_wr_en)
				atoms_used = cfg_wr_data;
			outstanding = expected_weights.size();
		end
	end

endmodule

// ===== test/tb.sv =====
// tb: stimulus and verdict for the Gaussian pair weight evaluator.
// Depends on gpw_pkg, gpw_req_if, gpw_rsp_if, gaussian_pair_weight_eval and
// gpw_weight_checker.
module tb;
	import gpw_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int DRAIN_WAIT  = 500;

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [6:0] cfg_wr_data;
	logic       calm;       // no idling on either side while set
	int         errors;
	int         outstanding;
	int         cycles;

	// centers as last loaded, so points can be aimed near atoms
	logic [31:0] ctr_x [MAX_ATOMS];
	logic [31:0] ctr_y [MAX_ATOMS];
	logic [31:0] ctr_z [MAX_ATOMS];

	gpw_req_if req_ch ();
	gpw_rsp_if rsp_ch ();

	gaussian_pair_weight_eval u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req_ch),
		.rsp         (rsp_ch)
	);

	gpw_weight_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// run watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// result side backpressure, ~25% stall unless calm
	always @(negedge clk)
		rsp_ch.ready = calm || ($urandom_range(99) >= 25);

	// one transfer on the request channel; random idle cycles ahead of it
	task automatic send(logic op, logic [5:0] slot, logic term,
			logic [31:0] px, logic [31:0] py, logic [31:0] pz,
			logic [31:0] qx, logic [31:0] qy, logic [31:0] qz,
			logic [31:0] expo, logic [31:0] wt, logic [31:0] sep);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 25) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.operation = op;
		req_ch.slot      = slot;
		req_ch.term      = term;
		req_ch.px        = px;
		req_ch.py        = py;
		req_ch.pz        = pz;
		req_ch.qx        = qx;
		req_ch.qy        = qy;
		req_ch.qz        = qz;
		req_ch.exponent  = expo;
		req_ch.weight    = wt;
		req_ch.distance  = sep;
		req_ch.valid     = 1'b1;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// load: unused q and distance fields carry noise
	task automatic load_term(logic [5:0] slot, logic term, logic [31:0] x,
			logic [31:0] y, logic [31:0] z, logic [31:0] expo, logic [31:0] wt);
		ctr_x[slot] = x;
		ctr_y[slot] = y;
		ctr_z[slot] = z;
		send(OP_LOAD, slot, term, x, y, z, $urandom, $urandom, $urandom, expo, wt,
			$urandom);
	endtask

	task automatic evaluate(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
			logic [31:0] qx, logic [31:0] qy, logic [31:0] qz, logic [31:0] sep);
		send(OP_EVAL, 6'($urandom), 1'($urandom), px, py, pz, qx, qy, qz, $urandom,
			$urandom, sep);
	endtask

	// drop valid, then wait out every pending result
	task automatic wait_idle();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_atoms(logic [6:0] n);
		@(negedge clk);
		cfg_wr_en   = 1'b1;
		cfg_wr_data = n;
		@(negedge clk);
		cfg_wr_en   = 1'b0;
	endtask

	// coordinate within about +-2.0 of c
	function automatic logic [31:0] near(logic [31:0] c);
		return c + $urandom_range(32'h3FFFF) - 32'h20000;
	endfunction

	function automatic logic [31:0] pick_coord(logic [31:0] c);
		case ($urandom_range(3))
			0:       return $urandom;
			1:       return 32'($signed($urandom_range(32'h1FFFFF)) - 32'sh100000);
			default: return near(c);
		endcase
	endfunction

	// mostly small exponents so the Gaussians stay visible
	function automatic logic [31:0] pick_expo();
		case ($urandom_range(3))
			0:       return $urandom;
			1:       return $urandom_range(32'hFF);
			default: return $urandom_range(32'h3FFFF);
		endcase
	endfunction

	function automatic logic [31:0] pick_dist();
		case ($urandom_range(9))
			0:       return 32'd0;
			1, 2:    return $urandom_range(1, 32'hFF);
			3, 4, 5: return $urandom_range(1, 32'hFFFFF);
			default: return $urandom;
		endcase
	endfunction

	// one random item: mostly evaluates aimed at loaded atoms, some loads
	task automatic random_item(int n);
		int a;
		int b;
		a = $urandom_range((n > 0) ? n - 1 : 0);
		b = $urandom_range((n > 0) ? n - 1 : 0);
		if ($urandom_range(9) < 3)
			load_term(6'($urandom), 1'($urandom), pick_coord(ctr_x[a]),
				pick_coord(ctr_y[a]), pick_coord(ctr_z[a]), pick_expo(), $urandom);
		else
			evaluate(pick_coord(ctr_x[a]), pick_coord(ctr_y[a]), pick_coord(ctr_z[a]),
				pick_coord(ctr_x[b]), pick_coord(ctr_y[b]), pick_coord(ctr_z[b]),
				pick_dist());
	endtask

	initial begin
		int          order [N_TERMS];
		int          j;
		int          tmp;
		logic [6:0]  phase_n [10];
		int          phase_len [10];
		logic [31:0] lo;
		logic [31:0] hi;

		lo = 32'h8000_0000;
		hi = 32'h7FFF_FFFF;
		cycles           = 0;
		calm             = 1'b0;
		arst_n           = 1'b0;
		cfg_wr_en        = 1'b0;
		cfg_wr_data      = '0;
		rsp_ch.ready     = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.operation = OP_LOAD;
		req_ch.slot      = '0;
		req_ch.term      = 1'b0;
		req_ch.px        = '0;
		req_ch.py        = '0;
		req_ch.pz        = '0;
		req_ch.qx        = '0;
		req_ch.qy        = '0;
		req_ch.qz        = '0;
		req_ch.exponent  = '0;
		req_ch.weight    = '0;
		req_ch.distance  = '0;
		for (int i = 0; i < MAX_ATOMS; i++) begin
			ctr_x[i] = 0;
			ctr_y[i] = 0;
			ctr_z[i] = 0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, no atoms in use: zero distance saturates, others give zero
		evaluate($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 32'd0);
		evaluate(lo, lo, lo, hi, hi, hi, 32'hFFFF_FFFF);
		evaluate(hi, lo, hi, lo, hi, lo, 32'd1);

		// field extremes on load; slot 63 and both terms
		load_term(6'd0, 1'b0, lo, lo, lo, 32'd0, 32'hFFFF_FFFF);
		load_term(6'd0, 1'b1, lo, lo, lo, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		load_term(6'd1, 1'b0, hi, hi, hi, 32'd1, 32'd1);
		load_term(6'd1, 1'b1, hi, hi, hi, 32'h0001_0000, 32'h0001_0000);
		load_term(6'd63, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		load_term(6'd63, 1'b1, $urandom, $urandom, $urandom, 32'h0000_8000, $urandom);
		wait_idle();
		write_atoms(7'd2);

		// point on the max-weight atom, tiny distance: overflow
		evaluate(lo, lo, lo, lo, lo, lo, 32'd1);
		// opposite corners of the coordinate range, largest distance
		evaluate(lo, lo, lo, hi, hi, hi, 32'hFFFF_FFFF);
		evaluate(hi, hi, hi, lo, lo, lo, 32'h0001_0000);
		// point half a unit from an atom: exp argument in range
		evaluate(hi - 32'h8000, hi, hi, hi, hi - 32'h8000, hi, $urandom);
		evaluate(lo, lo, lo, lo, lo, lo, 32'd0);

		// fill the whole table in shuffled order with evaluates mixed in;
		// atoms 0 and 1 stay fully written, so two in use is always legal
		for (int i = 0; i < N_TERMS; i++)
			order[i] = i;
		for (int i = N_TERMS - 1; i > 0; i--) begin
			j        = $urandom_range(i);
			tmp      = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		for (int i = 0; i < N_TERMS; i++) begin
			j = order[i] / TERMS_PER_ATOM;
			load_term(6'(j), 1'(order[i]), pick_coord(32'($urandom_range(32'hFFFFF))),
				pick_coord(32'($urandom_range(32'hFFFFF))),
				pick_coord(32'($urandom_range(32'hFFFFF))), pick_expo(), $urandom);
			if ($urandom_range(9) < 3)
				random_item(2);
		end

		// atom counts, extremes included; 127 acts as the full table
		phase_n = '{7'd64, 7'd127, 7'd1, 7'd3, 7'd0, 7'd8, 7'd16, 7'd2,
			7'($urandom_range(1, 12)), 7'd64};
		phase_len = '{10, 10, 40, 40, 20, 40, 12, 40, 40, 6};
		for (int p = 0; p < 10; p++) begin
			wait_idle();
			write_atoms(phase_n[p]);
			calm = (p == 5);
			for (int i = 0; i < phase_len[p]; i++)
				random_item((phase_n[p] > MAX_ATOMS) ? MAX_ATOMS : int'(phase_n[p]));
			calm = 1'b0;
		end

		wait_idle();
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== gaussian_pair_weight_eval.f =====
hw/rtl/gpw_pkg.sv
hw/rtl/gpw_req_if.sv
hw/rtl/gpw_rsp_if.sv
hw/rtl/gpw_ram.sv
hw/rtl/gpw_arg.sv
hw/rtl/gpw_cell.sv
hw/rtl/gaussian_pair_weight_eval.sv
hw/rtl/gpw_chk.sv
test/gpw_weight_checker.sv
test/tb.sv
